// ===== hw/rtl/wgb_pkg.sv =====
// ----------------------------------------------------------------------------
// wgb_pkg
// Shared types, constants and weight helpers for the window gaussian blur.
// ----------------------------------------------------------------------------
package wgb_pkg;

    // default geometry
    localparam int KERNEL_SIZE_DEF = 5;
    localparam int MAX_WIDTH_DEF   = 1024;

    // field widths
    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int OUTCOL_W  = 10;
    localparam int IMG_W_W   = 11;
    localparam int IMG_H_W   = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // raster arithmetic width, holds the largest frame dimension plus one
    localparam int CNT_W      = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIX_MAX    = 255;

    // register reset values
    localparam logic [IMG_W_W-1:0] IMG_W_RESET = IMG_W_W'(1024);
    localparam logic [IMG_H_W-1:0] IMG_H_RESET = IMG_H_W'(768);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_idx;

    // input transaction payload
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
    } t_pix_in;

    // output transaction payload
    typedef struct packed {
        logic [PIX_W-1:0]    filtered_value;
        logic [ROW_W-1:0]    out_row;
        logic [OUTCOL_W-1:0] out_col;
        logic                last_of_frame;
    } t_res_out;

    // position and flags that travel alongside a pixel
    typedef struct packed {
        logic                emit;
        logic [ROW_W-1:0]    out_row;
        logic [OUTCOL_W-1:0] out_col;
        logic                last;
    } t_meta;

    // log2 of the weight at window position (r, c)
    function automatic int weight_exp(input int k, input int r, input int c);
        int m;
        int dr;
        int dc;
        int e;
        m  = k >> 1;
        dr = (r > m) ? (r - m) : (m - r);
        dc = (c > m) ? (c - m) : (m - c);
        e  = m + 1 - dr - dc;
        if (e < 0) begin
            e = 0;
        end
        return e;
    endfunction

    // sum of all window weights
    function automatic int weight_total(input int k);
        int total;
        total = 0;
        for (int r = 0; r < k; r++) begin
            for (int c = 0; c < k; c++) begin
                total = total + (1 << weight_exp(k, r, c));
            end
        end
        return total;
    endfunction

endpackage

// ===== hw/rtl/wgb_stream_if.sv =====
// ----------------------------------------------------------------------------
// wgb_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface wgb_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/wgb_ram.sv =====
// ----------------------------------------------------------------------------
// wgb_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port, read returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/wgb_line_window.sv =====
// ----------------------------------------------------------------------------
// wgb_line_window
// Raster counters, line buffers and the sliding pixel window.
// ----------------------------------------------------------------------------
module wgb_line_window import wgb_pkg::*; #(
    parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_acc,
    input  logic [PIX_W-1:0]                             i_pixel,
    input  logic [IMG_W_W-1:0]                           i_img_w,
    input  logic [IMG_H_W-1:0]                           i_img_h,
    output logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] o_window,
    output t_meta                                        o_meta
);
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int LINES  = KERNEL_SIZE - 1;
    localparam int HALF   = KERNEL_SIZE / 2;
    localparam int BACK   = KERNEL_SIZE - 1 - HALF;

    logic [ADDR_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;
    logic [CNT_W-1:0]  eff_w;
    logic [CNT_W-1:0]  eff_h;
    logic [CNT_W-1:0]  col_p1;
    logic [CNT_W-1:0]  row_p1;
    logic              col_end;
    logic              row_end;
    t_meta             n_meta;

    logic              r_s1_valid;
    t_meta             r_s1_meta;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [ADDR_W-1:0] r_s1_addr;

    logic                         wr;
    logic [LINES-1:0][PIX_W-1:0]  ram_q;
    logic [LINES-1:0][PIX_W-1:0]  line_wdata;
    logic [KERNEL_SIZE-1:0][PIX_W-1:0] colv;
    logic                         r_byp;
    logic [LINES-1:0][PIX_W-1:0]  r_byp_data;

    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] r_win;
    t_meta             r_meta;

    // frame size in use, zero treated as one and large values saturated
    always_comb begin
        if (i_img_w == '0) begin
            eff_w = CNT_W'(1);
        end else if (CNT_W'(i_img_w) > CNT_W'(MAX_WIDTH)) begin
            eff_w = CNT_W'(MAX_WIDTH);
        end else begin
            eff_w = CNT_W'(i_img_w);
        end
        if (i_img_h == '0) begin
            eff_h = CNT_W'(1);
        end else if (i_img_h > CNT_W'(MAX_HEIGHT)) begin
            eff_h = CNT_W'(MAX_HEIGHT);
        end else begin
            eff_h = i_img_h;
        end
    end

    // raster position of the incoming pixel and its output tag
    always_comb begin
        col_p1         = CNT_W'(r_col) + CNT_W'(1);
        row_p1         = CNT_W'(r_row) + CNT_W'(1);
        col_end        = (col_p1 >= eff_w);
        row_end        = (row_p1 >= eff_h);
        n_meta.emit    = (r_row >= ROW_W'(KERNEL_SIZE - 1))
                      && (r_col >= ADDR_W'(KERNEL_SIZE - 1));
        n_meta.out_row = r_row - ROW_W'(BACK);
        n_meta.out_col = OUTCOL_W'(r_col - ADDR_W'(BACK));
        n_meta.last    = row_end && col_end;
    end

    // column of the pixel in the line stage, bypassing a write to the same column
    assign wr = i_en && r_s1_valid;

    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            colv[k] = r_byp ? r_byp_data[k] : ram_q[k];
        end
        colv[KERNEL_SIZE-1] = r_s1_pix;
    end

    // line buffers, each line moves up one row at the current column
    for (genvar g = 0; g < LINES; g++) begin : g_line
        if (g < LINES - 1) begin : g_mid
            assign line_wdata[g] = colv[g+1];
        end else begin : g_top
            assign line_wdata[g] = r_s1_pix;
        end

        wgb_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (wr),
            .i_waddr (r_s1_addr),
            .i_wdata (line_wdata[g]),
            .i_re    (i_acc),
            .i_raddr (r_col),
            .o_rdata (ram_q[g])
        );
    end

    // counters, line stage and window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_meta.emit <= 1'b0;
        end else begin
            if (i_acc) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : ROW_W'(row_p1);
                end else begin
                    r_col <= ADDR_W'(col_p1);
                end
                r_byp      <= wr && (r_s1_addr == r_col);
                r_byp_data <= line_wdata;
                r_s1_meta  <= n_meta;
                r_s1_pix   <= i_pixel;
                r_s1_addr  <= r_col;
            end
            if (i_en) begin
                r_s1_valid     <= i_acc;
                r_meta.emit    <= r_s1_valid && r_s1_meta.emit;
                r_meta.out_row <= r_s1_meta.out_row;
                r_meta.out_col <= r_s1_meta.out_col;
                r_meta.last    <= r_s1_meta.last;
            end
            if (wr) begin
                for (int k = 0; k < KERNEL_SIZE; k++) begin
                    for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
                        r_win[k][j] <= r_win[k][j+1];
                    end
                    r_win[k][KERNEL_SIZE-1] <= colv[k];
                end
            end
        end
    end

    assign o_window = r_win;
    assign o_meta   = r_meta;
endmodule

// ===== hw/rtl/wgb_conv.sv =====
// ----------------------------------------------------------------------------
// wgb_conv
// Weighted window sum by shift and add, then division by the weight sum.
// ----------------------------------------------------------------------------
module wgb_conv import wgb_pkg::*; #(
    parameter int KERNEL_SIZE = KERNEL_SIZE_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_en,
    input  logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] i_window,
    input  t_meta                                              i_meta,
    output logic                                               o_valid,
    output t_res_out                                           o_res
);
    localparam int W_TOTAL = weight_total(KERNEL_SIZE);
    localparam int SUM_W   = $clog2(PIX_MAX * W_TOTAL + 1);
    localparam int DIV_S   = SUM_W + $clog2(W_TOTAL);
    localparam longint unsigned RECIP =
        ((longint'(1) << DIV_S) + longint'(W_TOTAL) - 1) / longint'(W_TOTAL);
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = SUM_W + RECIP_W;

    logic [KERNEL_SIZE-1:0][SUM_W-1:0] n_rs;
    logic [KERNEL_SIZE-1:0][SUM_W-1:0] r_rs;
    logic [SUM_W-1:0]                  n_sum;
    logic [SUM_W-1:0]                  r_sum;
    logic [PROD_W-1:0]                 prod;
    logic [PIX_W-1:0]                  r_quot;
    t_meta                             r_m1;
    t_meta                             r_m2;
    t_meta                             r_m3;

    // weighted row sums, each weight a power of two
    always_comb begin
        logic [SUM_W-1:0] acc;
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            acc = '0;
            for (int c = 0; c < KERNEL_SIZE; c++) begin
                acc = acc + (SUM_W'(i_window[r][c]) << weight_exp(KERNEL_SIZE, r, c));
            end
            n_rs[r] = acc;
        end
    end

    // total over rows
    always_comb begin
        n_sum = '0;
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            n_sum = n_sum + r_rs[r];
        end
    end

    // truncating divide by the weight sum through a reciprocal
    assign prod = PROD_W'(r_sum) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1.emit <= 1'b0;
            r_m2.emit <= 1'b0;
            r_m3.emit <= 1'b0;
        end else if (i_en) begin
            r_rs   <= n_rs;
            r_m1   <= i_meta;
            r_sum  <= n_sum;
            r_m2   <= r_m1;
            r_quot <= PIX_W'(prod >> DIV_S);
            r_m3   <= r_m2;
        end
    end

    assign o_valid              = r_m3.emit;
    assign o_res.filtered_value = r_quot;
    assign o_res.out_row        = r_m3.out_row;
    assign o_res.out_col        = r_m3.out_col;
    assign o_res.last_of_frame  = r_m3.last;
endmodule

// ===== hw/rtl/wgb_out_skid.sv =====
// ----------------------------------------------------------------------------
// wgb_out_skid
// Output register with one skid entry, decoupling the pipeline from ready.
// ----------------------------------------------------------------------------
module wgb_out_skid import wgb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_res_out         i_res,
    output logic             o_full,
    wgb_stream_if.source     o_res
);
    logic     r_out_valid;
    t_res_out r_out;
    logic     r_sk_valid;
    t_res_out r_sk;
    logic     pop;

    assign pop = r_out_valid && o_res.ready;

    // output and skid occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (pop) begin
                r_out      <= r_sk;
                r_sk_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out       <= i_res;
                r_out_valid <= 1'b1;
            end else begin
                r_sk       <= i_res;
                r_sk_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_full      = r_sk_valid;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
endmodule

// ===== hw/rtl/window_gaussian_blur.sv =====
// ----------------------------------------------------------------------------
// window_gaussian_blur
// Path: line stage, window, row sums, total, quotient and output register.
// Throughput: one pixel per cycle, set by one read and one write per cycle on
// each line buffer RAM; the pipeline holds only while the output skid is full.
// Reset: raster counters to zero, pipeline and output empty, width 1024 and
// height 768; line buffer contents stay undefined until written, no clearing.
// ----------------------------------------------------------------------------
module window_gaussian_blur import wgb_pkg::*; #(
    parameter int KERNEL_SIZE = KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    wgb_stream_if.sink           i_pix,
    wgb_stream_if.source         o_res
);
    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;
    logic               en;
    logic               acc;
    logic               full;
    logic               conv_valid;
    t_res_out           conv_res;
    t_meta              win_meta;
    logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] window;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMG_W_RESET;
            r_img_h <= IMG_H_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH: begin
                    r_img_w <= i_cfg_data[IMG_W_W-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    r_img_h <= i_cfg_data[IMG_H_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline advances while the skid entry is free
    assign en          = !full;
    assign i_pix.ready = en;
    assign acc         = i_pix.valid && en;

    wgb_line_window #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_line_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_acc    (acc),
        .i_pixel  (i_pix.data.pixel),
        .i_img_w  (r_img_w),
        .i_img_h  (r_img_h),
        .o_window (window),
        .o_meta   (win_meta)
    );

    wgb_conv #(
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_window (window),
        .i_meta   (win_meta),
        .o_valid  (conv_valid),
        .o_res    (conv_res)
    );

    wgb_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && conv_valid),
        .i_res   (conv_res),
        .o_full  (full),
        .o_res   (o_res)
    );
endmodule

// ===== test/wgb_blur_checker.sv =====
// ----------------------------------------------------------------------------
// wgb_blur_checker
// Watches the pixel and result channels and the register port of the window
// gaussian blur, keeps its own copy of the line buffers, window and raster
// position, and checks every result transaction field by field against the
// oldest predicted blurred pixel.
// ----------------------------------------------------------------------------
module wgb_blur_checker import wgb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_pix_valid,
    input  logic                 i_pix_ready,
    input  t_pix_in              i_pix_data,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  t_res_out             i_res_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KS   = KERNEL_SIZE_DEF;
    localparam int MW   = MAX_WIDTH_DEF;
    localparam int MID  = KS / 2;
    localparam int BACK = KS - 1 - MID;

    // kernel taps and their sum
    int unsigned tap_weight [KS][KS];
    int unsigned tap_sum;

    // shadow of the block state
    logic [PIX_W-1:0]   line_mem [KS-1][MW];
    logic [PIX_W-1:0]   win [KS][KS];
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;

    // blurred pixels still to come out of the block
    t_res_out blurred_q [$];
    int       fails   = 0;
    int       checked = 0;

    // taps halve per step away from the centre, never below one
    initial begin
        int dr;
        int dc;
        int e;
        tap_sum = 0;
        for (int r = 0; r < KS; r++) begin
            for (int c = 0; c < KS; c++) begin
                dr = (r > MID) ? (r - MID) : (MID - r);
                dc = (c > MID) ? (c - MID) : (MID - c);
                e  = MID + 1 - dr - dc;
                if (e < 0) begin
                    e = 0;
                end
                tap_weight[r][c] = 1 << e;
                tap_sum          = tap_sum + tap_weight[r][c];
            end
        end
    end

    // one line per mismatch, the count goes on past the print cap
    task automatic report_mismatch(input string msg);
        if (fails < 40) begin
            $display("mismatch: %s", msg);
        end
        fails++;
    endtask

    // advance the shadow by one pixel, returns 1 when a blurred pixel is due
    function automatic bit blur_step(input logic [PIX_W-1:0] px, output t_res_out res);
        int unsigned      w_eff;
        int unsigned      h_eff;
        int unsigned      lc;
        int unsigned      acc;
        logic [PIX_W-1:0] colv [KS];
        bit               hit;

        res = '0;
        hit = 1'b0;
        w_eff = (width_reg == 0) ? 1 : ((width_reg > MW) ? MW : width_reg);
        h_eff = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        lc    = (col_pos < MW) ? col_pos : MW - 1;

        // column from the line buffers, then shift them up
        for (int k = 0; k < KS - 1; k++) begin
            colv[k] = line_mem[k][lc];
        end
        colv[KS-1] = px;
        for (int k = 0; k < KS - 2; k++) begin
            line_mem[k][lc] = line_mem[k+1][lc];
        end
        line_mem[KS-2][lc] = px;

        // window slides left, new column on the right
        for (int k = 0; k < KS; k++) begin
            for (int j = 0; j < KS - 1; j++) begin
                win[k][j] = win[k][j+1];
            end
            win[k][KS-1] = colv[k];
        end

        // interior pixel once the window sits fully inside the frame
        if (row_pos >= KS - 1 && col_pos >= KS - 1) begin
            acc = 0;
            for (int k = 0; k < KS; k++) begin
                for (int j = 0; j < KS; j++) begin
                    acc = acc + win[k][j] * tap_weight[k][j];
                end
            end
            res.filtered_value = PIX_W'(acc / tap_sum);
            res.out_row        = ROW_W'(row_pos - BACK);
            res.out_col        = OUTCOL_W'(col_pos - BACK);
            res.last_of_frame  = (row_pos + 1 >= h_eff && col_pos + 1 >= w_eff);
            hit = 1'b1;
        end

        // raster position
        if (col_pos + 1 >= w_eff) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h_eff) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return hit;
    endfunction

    // sample every transaction at the rising edge
    always @(posedge i_clk) begin
        t_res_out want;
        t_res_out got;
        if (!i_rst_n) begin
            width_reg  = IMG_W_RESET;
            height_reg = IMG_H_RESET;
            col_pos    = 0;
            row_pos    = 0;
            for (int k = 0; k < KS - 1; k++) begin
                for (int c = 0; c < MW; c++) begin
                    line_mem[k][c] = '0;
                end
            end
            for (int k = 0; k < KS; k++) begin
                for (int j = 0; j < KS; j++) begin
                    win[k][j] = '0;
                end
            end
            blurred_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IMAGE_WIDTH: begin
                        width_reg = i_cfg_data[IMG_W_W-1:0];
                    end
                    CFG_IMAGE_HEIGHT: begin
                        height_reg = i_cfg_data[IMG_H_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_pix_valid && i_pix_ready) begin
                if (blur_step(i_pix_data.pixel, want)) begin
                    blurred_q.push_back(want);
                end
            end
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (blurred_q.size() == 0) begin
                    report_mismatch($sformatf("result row %0d col %0d with nothing expected",
                                              got.out_row, got.out_col));
                end else begin
                    want = blurred_q.pop_front();
                    if (got.filtered_value !== want.filtered_value) begin
                        report_mismatch($sformatf("result %0d filtered_value expected %0d, got %0d",
                                                  checked, want.filtered_value,
                                                  got.filtered_value));
                    end
                    if (got.out_row !== want.out_row) begin
                        report_mismatch($sformatf("result %0d out_row expected %0d, got %0d",
                                                  checked, want.out_row, got.out_row));
                    end
                    if (got.out_col !== want.out_col) begin
                        report_mismatch($sformatf("result %0d out_col expected %0d, got %0d",
                                                  checked, want.out_col, got.out_col));
                    end
                    if (got.last_of_frame !== want.last_of_frame) begin
                        report_mismatch($sformatf("result %0d last_of_frame expected %0d, got %0d",
                                                  checked, want.last_of_frame,
                                                  got.last_of_frame));
                    end
                    checked++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= blurred_q.size();
        o_checked    <= checked;
    end

endmodule

// ===== test/window_gaussian_blur_test.sv =====
// ----------------------------------------------------------------------------
// window_gaussian_blur_test
// Streams raster frames of many geometries through the blur, with random
// gaps on the pixel side and random back-pressure on the result side, and
// leaves all checking to the checker instance beside the block.
// ----------------------------------------------------------------------------
module window_gaussian_blur_test import wgb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_TAIL    = 150;

    typedef enum int {
        PIX_UNIFORM,
        PIX_EXTREME,
        PIX_BRIGHT,
        PIX_DARK
    } t_pix_style;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int checked;

    bit send_idle_on  = 1'b1;
    bit sink_stall_on = 1'b1;
    int stall_left    = 0;
    int eff_w         = 1024;
    int eff_h         = 768;
    int pixels_sent   = 0;
    int frames_done   = 0;
    int geometries    = 0;
    int random_sent   = 0;

    wgb_stream_if #(.T(t_pix_in))  pix_if ();
    wgb_stream_if #(.T(t_res_out)) res_if ();

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    window_gaussian_blur DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    wgb_blur_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_pix_valid  (pix_if.valid),
        .i_pix_ready  (pix_if.ready),
        .i_pix_data   (pix_if.data),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res_data   (res_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // result side back-pressure in random bursts
    always @(posedge clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 6);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(input t_pix_style style);
        case (style)
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PIX_BRIGHT:  return PIX_W'($urandom_range(224, 255));
            PIX_DARK:    return PIX_W'($urandom_range(0, 31));
            default:     return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one pixel transaction, with an optional gap or hold-off in front
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        if (send_idle_on && $urandom_range(0, 7) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end else if (send_idle_on && $urandom_range(0, 399) == 0) begin
            // hold off until every pending result has been handed over
            pix_if.valid <= 1'b0;
            do @(posedge clk); while (pending != 0);
        end
        pix_if.valid      <= 1'b1;
        pix_if.data.pixel <= px;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        pixels_sent++;
    endtask

    // stop sending, let the results drain and the pipeline settle
    task automatic finish_phase();
        pix_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // both registers, then the spare index which must change nothing
    task automatic set_geometry(input logic [CFG_W-1:0] wdata, input logic [CFG_W-1:0] hdata);
        logic [IMG_W_W-1:0] wv;
        logic [IMG_H_W-1:0] hv;
        wv = wdata[IMG_W_W-1:0];
        hv = hdata[IMG_H_W-1:0];
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IMAGE_WIDTH;
        cfg_data <= wdata;
        @(posedge clk);
        cfg_idx  <= CFG_IMAGE_HEIGHT;
        cfg_data <= hdata;
        @(posedge clk);
        cfg_idx  <= CFG_IDX_SPARE;
        cfg_data <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we   <= 1'b0;
        eff_w = (wv == 0) ? 1 : ((wv > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : wv);
        eff_h = (hv == 0) ? 1 : ((hv > MAX_HEIGHT) ? MAX_HEIGHT : hv);
        geometries++;
    endtask

    task automatic run_frames(input int n_frames, input t_pix_style style);
        repeat (n_frames * eff_w * eff_h) send_pixel(pick_pixel(style));
        frames_done += n_frames;
        finish_phase();
    endtask

    // stimulus and verdict
    initial begin
        int         w;
        int         h;
        int         n;
        int         nf;
        t_pix_style style;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_IMAGE_WIDTH;
        cfg_data     <= '0;
        pix_if.valid <= 1'b0;
        pix_if.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero width and height act as one pixel frames
        set_geometry(13'h0000, 13'h0000);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        frames_done += 2;
        finish_phase();

        // upper data bits dropped by the width register, one full bright window
        set_geometry(13'h1805, 13'd5);
        repeat (25) send_pixel(8'hFF);
        frames_done++;
        finish_phase();

        // geometry shrunk mid-frame: both counters wrap at the next advance
        set_geometry(13'd8, 13'd4096);
        repeat (9 * 8 + 7) send_pixel(pick_pixel(PIX_UNIFORM));
        finish_phase();
        set_geometry(13'd6, 13'd4);
        send_pixel(pick_pixel(PIX_EXTREME));
        frames_done++;
        finish_phase();

        // height beyond the frame limit saturates, frame then cut short after eight rows
        set_geometry(13'd5, 13'h1FFF);
        repeat (7 * 5) send_pixel(pick_pixel(PIX_UNIFORM));
        finish_phase();
        set_geometry(13'd5, 13'd8);
        repeat (5) send_pixel(pick_pixel(PIX_DARK));
        frames_done++;
        finish_phase();

        // width beyond the line buffers saturates: one full row, then narrowed to five
        set_geometry(13'h07FF, 13'd5);
        repeat (MAX_WIDTH_DEF) send_pixel(pick_pixel(PIX_UNIFORM));
        finish_phase();
        set_geometry(13'd5, 13'd5);
        repeat (4 * 5) send_pixel(pick_pixel(PIX_UNIFORM));
        frames_done++;
        finish_phase();

        // random geometries, mostly frames big enough for a window
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent > RANDOM_ITEMS - CALM_TAIL) begin
                send_idle_on  = 1'b0;
                sink_stall_on = 1'b0;
            end
            n = $urandom_range(0, 19);
            if (n < 14) begin
                w = $urandom_range(5, 20);
            end else if (n < 17) begin
                w = $urandom_range(0, 4);
            end else begin
                w = $urandom_range(21, 64);
            end
            n = $urandom_range(0, 9);
            if (n < 7) begin
                h = $urandom_range(5, 10);
            end else if (n < 9) begin
                h = $urandom_range(0, 4);
            end else begin
                h = $urandom_range(11, 16);
            end
            if (w > 20) begin
                h  = $urandom_range(5, 6);
                nf = 1;
            end else if (w * h > 64) begin
                nf = 1;
            end else begin
                nf = $urandom_range(1, 3);
            end
            n     = $urandom_range(0, 5);
            style = (n > 3) ? PIX_UNIFORM : t_pix_style'(n);
            set_geometry(CFG_W'(w) | (CFG_W'($urandom_range(0, 3)) << IMG_W_W), CFG_W'(h));
            run_frames(nf, style);
            random_sent += nf * eff_w * eff_h;
        end

        $display("covered %0d pixels in %0d frames over %0d geometries", pixels_sent,
                 frames_done, geometries);
        $display("checked %0d blurred pixels, %0d mismatches, %0d never arrived", checked,
                 fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("window_gaussian_blur_test: PASS");
        end else begin
            $display("window_gaussian_blur_test: FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("timed out with %0d results outstanding", pending);
        $display("window_gaussian_blur_test: FAIL");
        $finish;
    end

endmodule
